FILE: hw/rtl/lcs_pkg.sv
// shared types and constants for the linear congruence solver
`timescale 1ns / 1ps

package lcs_pkg;

  // operand and gcd field widths fixed by the interface
  localparam int OpW  = 32;
  localparam int GcdW = 31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EUC_CHK,
    ST_EUC_DIV,
    ST_UPD0,
    ST_UPD1,
    ST_UPD2,
    ST_SOL_CHK,
    ST_B_DIV,
    ST_SCL0,
    ST_SCL1,
    ST_SCL2,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MAC_U0,
    MAC_U1,
    MAC_X,
    MAC_K
  } mac_op_t;

  typedef struct packed {
    logic    busy;
    logic    load;
    logic    div_start;
    logic    div_b;
    logic    euc_take;
    logic    mac_en;
    mac_op_t mac_op;
    logic    upd_u0;
    logic    upd_u1;
    logic    scale_take;
    logic    take_x;
    logic    take_k;
    logic    no_sol;
    logic    fin;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic p_zero;
    logic q_zero;
    logic div_done;
    logic rem_zero;
  } stat_t;

endpackage

FILE: hw/rtl/linear_congruence_solver_core.sv
// top level: solves a*x = b (mod n) with extended euclid on a shared divider
`timescale 1ns / 1ps
//
// usage
//   an item (coef_a, modulus_n, rhs_b) is taken at a rising edge with start high
//   and busy low. busy then stays high until the result is issued
//   the result sits on has_solution, x_solution, k_solution and gcd_value,
//   marked by done for exactly one cycle; the receiver cannot hold it off and
//   done coincides with busy going low, so the next item may start that cycle
// timing
//   one shared 32-bit restoring divider, one quotient bit per cycle, sets the pace
//   each euclid step is a check, a division in the divider and a coefficient
//   update through the shared multiply-accumulate unit
//   after the last step: scale division and scaling
//   the euclid step count is 0 when a is 0, and at most about 46 for 32-bit operands
//   when a and n are both 0, or the gcd does not divide b, the scaling is skipped
// reset
//   rst is synchronous, active high; it returns the sequencer to idle and
//   drops done. an item in flight is lost
//
module linear_congruence_solver_core #(
  parameter int WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lcs_pkg::OpW-1:0]    coef_a,
  input  logic signed [lcs_pkg::OpW-1:0]    modulus_n,
  input  logic signed [lcs_pkg::OpW-1:0]    rhs_b,
  output logic                              done,
  output logic                              has_solution,
  output logic signed [lcs_pkg::OpW-1:0]    x_solution,
  output logic signed [lcs_pkg::OpW-1:0]    k_solution,
  output logic [lcs_pkg::GcdW-1:0]          gcd_value
);

  // coefficients only matter modulo 2^min(WIDTH, 32)
  localparam int CW = (WIDTH < lcs_pkg::OpW) ? WIDTH : lcs_pkg::OpW;

  lcs_pkg::ctrl_t ctrl;
  lcs_pkg::stat_t stat;

  // operand signs and magnitudes
  logic                    a_neg, n_neg, b_neg;
  logic [lcs_pkg::OpW-1:0] a_mag, n_mag, b_in_mag, b_mag;

  // euclid remainders: q is the running gcd
  logic [lcs_pkg::OpW-1:0] p, q;
  logic [CW-1:0]           qt;

  // product of the step matrices: u is the first column, v the second
  logic [CW-1:0]           u0, u1, v0, v1;
  logic [CW-1:0]           scale;
  logic [CW-1:0]           x_res, k_res;
  logic                    sol_ok;

  // shared unit hookup
  logic                    div_done;
  logic [lcs_pkg::OpW-1:0] div_dividend, div_divisor, div_quo, div_rem;
  logic [CW-1:0]           mac_a, mac_b, mac_c, mac_res;
  logic                    mac_neg;

  assign a_mag    = coef_a[lcs_pkg::OpW-1] ? lcs_pkg::OpW'(-coef_a) : lcs_pkg::OpW'(coef_a);
  assign n_mag    = modulus_n[lcs_pkg::OpW-1] ? lcs_pkg::OpW'(-modulus_n)
                                              : lcs_pkg::OpW'(modulus_n);
  assign b_in_mag = rhs_b[lcs_pkg::OpW-1] ? lcs_pkg::OpW'(-rhs_b) : lcs_pkg::OpW'(rhs_b);

  assign stat.start    = start;
  assign stat.p_zero   = (p == '0);
  assign stat.q_zero   = (q == '0);
  assign stat.div_done = div_done;
  assign stat.rem_zero = (div_rem == '0);

  assign busy = ctrl.busy;

  lcs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // euclid step divides q by p; the closing division takes |b| over the gcd
  assign div_dividend = ctrl.div_b ? b_mag : q;
  assign div_divisor  = ctrl.div_b ? q : p;

  lcs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctrl.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // step update is u <- v - qt*u; scaling folds in the signs of a, n and b
  always_comb begin
    mac_a   = qt;
    mac_b   = u0;
    mac_c   = v0;
    mac_neg = 1'b1;
    unique case (ctrl.mac_op)
      lcs_pkg::MAC_U0: begin
        mac_a   = qt;
        mac_b   = u0;
        mac_c   = v0;
        mac_neg = 1'b1;
      end
      lcs_pkg::MAC_U1: begin
        mac_a   = qt;
        mac_b   = u1;
        mac_c   = v1;
        mac_neg = 1'b1;
      end
      lcs_pkg::MAC_X: begin
        mac_a   = v0;
        mac_b   = scale;
        mac_c   = '0;
        mac_neg = b_neg ^ a_neg;
      end
      lcs_pkg::MAC_K: begin
        mac_a   = v1;
        mac_b   = scale;
        mac_c   = '0;
        mac_neg = b_neg ^ n_neg;
      end
      default: begin
        mac_a   = qt;
        mac_b   = u0;
        mac_c   = v0;
        mac_neg = 1'b1;
      end
    endcase
  end

  lcs_mac #(
    .CW (CW)
  ) u_mac (
    .clk    (clk),
    .en     (ctrl.mac_en),
    .mul_a  (mac_a),
    .mul_b  (mac_b),
    .addend (mac_c),
    .negate (mac_neg),
    .result (mac_res)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_neg  <= coef_a[lcs_pkg::OpW-1];
      n_neg  <= modulus_n[lcs_pkg::OpW-1];
      b_neg  <= rhs_b[lcs_pkg::OpW-1];
      b_mag  <= b_in_mag;
      p      <= a_mag;
      q      <= n_mag;
      u0     <= CW'(1);
      u1     <= '0;
      v0     <= '0;
      v1     <= CW'(1);
      sol_ok <= 1'b1;
    end
    if (ctrl.euc_take) begin
      q  <= p;
      p  <= div_rem;
      qt <= div_quo[CW-1:0];
    end
    if (ctrl.upd_u0) begin
      v0 <= u0;
      u0 <= mac_res;
    end
    if (ctrl.upd_u1) begin
      v1 <= u1;
      u1 <= mac_res;
    end
    if (ctrl.scale_take) scale <= div_quo[CW-1:0];
    if (ctrl.take_x)     x_res <= mac_res;
    if (ctrl.take_k)     k_res <= mac_res;
    if (ctrl.no_sol)     sol_ok <= 1'b0;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.fin;
    end
  end

  // result item, sign-extended from the coefficient width
  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      has_solution <= sol_ok;
      x_solution   <= sol_ok ? lcs_pkg::OpW'(signed'(x_res)) : '0;
      k_solution   <= sol_ok ? lcs_pkg::OpW'(signed'(k_res)) : '0;
      gcd_value    <= q[lcs_pkg::GcdW-1:0];
    end
  end

endmodule

FILE: hw/rtl/lcs_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lcs_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lcs_pkg::OpW-1:0]      dividend,
  input  logic [lcs_pkg::OpW-1:0]      divisor,
  output logic                         done,
  output logic [lcs_pkg::OpW-1:0]      quotient,
  output logic [lcs_pkg::OpW-1:0]      remainder
);

  localparam int CntW = $clog2(lcs_pkg::OpW);

  logic                    running;
  logic [CntW-1:0]         cnt;
  logic [lcs_pkg::OpW-1:0] dsr;
  logic [lcs_pkg::OpW:0]   shifted;
  logic [lcs_pkg::OpW:0]   diff;
  logic                    qbit;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {remainder, quotient[lcs_pkg::OpW-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign qbit    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(lcs_pkg::OpW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (running) begin
      remainder <= qbit ? diff[lcs_pkg::OpW-1:0] : shifted[lcs_pkg::OpW-1:0];
      quotient  <= {quotient[lcs_pkg::OpW-2:0], qbit};
    end
  end

endmodule

FILE: hw/rtl/lcs_mac.sv
// shared multiply-accumulate unit, modulo 2^CW, registered result
`timescale 1ns / 1ps

module lcs_mac #(
  parameter int CW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] mul_a,
  input  logic [CW-1:0] mul_b,
  input  logic [CW-1:0] addend,
  input  logic          negate,
  output logic [CW-1:0] result
);

  logic [2*CW-1:0] prod_full;
  logic [CW-1:0]   prod;

  assign prod_full = (2*CW)'(mul_a) * (2*CW)'(mul_b);
  assign prod      = prod_full[CW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      result <= negate ? (addend - prod) : (addend + prod);
    end
  end

endmodule

FILE: hw/rtl/lcs_seq.sv
// sequencer for the euclid steps, the scale division and the scaling
`timescale 1ns / 1ps

module lcs_seq (
  input  logic            clk,
  input  logic            rst,
  input  lcs_pkg::stat_t  stat,
  output lcs_pkg::ctrl_t  ctrl
);

  lcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lcs_pkg::ST_IDLE: begin
        if (stat.start) state_next = lcs_pkg::ST_EUC_CHK;
      end
      lcs_pkg::ST_EUC_CHK: begin
        state_next = stat.p_zero ? lcs_pkg::ST_SOL_CHK : lcs_pkg::ST_EUC_DIV;
      end
      lcs_pkg::ST_EUC_DIV: begin
        if (stat.div_done) state_next = lcs_pkg::ST_UPD0;
      end
      lcs_pkg::ST_UPD0:    state_next = lcs_pkg::ST_UPD1;
      lcs_pkg::ST_UPD1:    state_next = lcs_pkg::ST_UPD2;
      lcs_pkg::ST_UPD2:    state_next = lcs_pkg::ST_EUC_CHK;
      lcs_pkg::ST_SOL_CHK: begin
        state_next = stat.q_zero ? lcs_pkg::ST_OUT : lcs_pkg::ST_B_DIV;
      end
      lcs_pkg::ST_B_DIV: begin
        if (stat.div_done) begin
          state_next = stat.rem_zero ? lcs_pkg::ST_SCL0 : lcs_pkg::ST_OUT;
        end
      end
      lcs_pkg::ST_SCL0:    state_next = lcs_pkg::ST_SCL1;
      lcs_pkg::ST_SCL1:    state_next = lcs_pkg::ST_SCL2;
      lcs_pkg::ST_SCL2:    state_next = lcs_pkg::ST_OUT;
      lcs_pkg::ST_OUT:     state_next = lcs_pkg::ST_IDLE;
      default:             state_next = lcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.mac_op = lcs_pkg::MAC_U0;
    ctrl.busy   = (state != lcs_pkg::ST_IDLE);
    unique case (state)
      lcs_pkg::ST_IDLE:    ctrl.load = stat.start;
      lcs_pkg::ST_EUC_CHK: ctrl.div_start = !stat.p_zero;
      lcs_pkg::ST_EUC_DIV: ctrl.euc_take = stat.div_done;
      lcs_pkg::ST_UPD0: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = lcs_pkg::MAC_U0;
      end
      lcs_pkg::ST_UPD1: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = lcs_pkg::MAC_U1;
        ctrl.upd_u0 = 1'b1;
      end
      lcs_pkg::ST_UPD2:    ctrl.upd_u1 = 1'b1;
      lcs_pkg::ST_SOL_CHK: begin
        ctrl.div_b     = 1'b1;
        ctrl.div_start = !stat.q_zero;
        ctrl.no_sol    = stat.q_zero;
      end
      lcs_pkg::ST_B_DIV: begin
        ctrl.scale_take = stat.div_done && stat.rem_zero;
        ctrl.no_sol     = stat.div_done && !stat.rem_zero;
      end
      lcs_pkg::ST_SCL0: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = lcs_pkg::MAC_X;
      end
      lcs_pkg::ST_SCL1: begin
        ctrl.mac_en = 1'b1;
        ctrl.mac_op = lcs_pkg::MAC_K;
        ctrl.take_x = 1'b1;
      end
      lcs_pkg::ST_SCL2:    ctrl.take_k = 1'b1;
      lcs_pkg::ST_OUT:     ctrl.fin = 1'b1;
      default:             ctrl.busy = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/lcs_checker.sv
// port-level checks for the linear congruence solver, bound to the top level
`timescale 1ns / 1ps

module lcs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic                           has_solution,
  input logic signed [lcs_pkg::OpW-1:0] x_solution,
  input logic signed [lcs_pkg::OpW-1:0] k_solution
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // busy only drops together with the result strobe
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // the strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // no solution means zero coefficients
  a_nosol_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !has_solution) |-> (x_solution == '0 && k_solution == '0))
    else $error("coefficients nonzero without a solution");

endmodule

bind linear_congruence_solver_core lcs_checker u_lcs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .has_solution (has_solution),
  .x_solution   (x_solution),
  .k_solution   (k_solution)
);
